// ===== rtl/pss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and constants for the priority sleep thread scheduler.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int MAX_THREADS = 8;
  localparam int IDX_W       = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);
  localparam int PRIO_W      = 8;
  localparam int TICK_W      = 32;
  localparam int OUT_IDX_W   = 3;

  localparam logic [PRIO_W-1:0] PRIO_NONE = 8'd255;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_TICK  = 2'd1,
    OP_SLEEP = 2'd2,
    OP_SCHED = 2'd3
  } op_t;

  typedef logic [MAX_THREADS-1:0][PRIO_W-1:0] prio_vec_t;
  typedef logic [MAX_THREADS-1:0][TICK_W-1:0] tick_vec_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } pick_t;

endpackage

// ===== rtl/pss_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_if
// Valid/ready channels for scheduler requests and scheduler results.
// ----------------------------------------------------------------------------
interface pss_in_if;
  logic                                valid;
  logic                                ready;
  pss_pkg::op_t                        op;
  logic [pss_pkg::PRIO_W-1:0]          priority_req;
  logic [pss_pkg::TICK_W-1:0]          sleep_ticks;

  modport source (output valid, output op, output priority_req, output sleep_ticks,
                  input ready);
  modport sink   (input valid, input op, input priority_req, input sleep_ticks,
                  output ready);
endinterface

interface pss_out_if;
  logic                                valid;
  logic                                ready;
  logic                                status;
  logic [pss_pkg::OUT_IDX_W-1:0]       running_thread;
  logic [pss_pkg::OUT_IDX_W-1:0]       added_index;

  modport source (output valid, output status, output running_thread,
                  output added_index, input ready);
  modport sink   (input valid, input status, input running_thread,
                  input added_index, output ready);
endinterface

// ===== rtl/pss_pick.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_pick
// Selects the ready thread with the lowest priority, ties going to the first
// thread met in ring order after the running thread.
// ----------------------------------------------------------------------------
module pss_pick (
  input  pss_pkg::prio_vec_t                prio,
  input  logic [pss_pkg::MAX_THREADS-1:0]   ready,
  input  logic [pss_pkg::CNT_W-1:0]         total,
  input  logic [pss_pkg::IDX_W-1:0]         running,
  output pss_pkg::pick_t                    pick
);
  import pss_pkg::*;

  localparam int RNK_W = CNT_W + 1;

  logic [CNT_W-1:0]  start;
  logic [RNK_W-1:0]  rank;
  logic [RNK_W-1:0]  best_rank;
  logic [PRIO_W-1:0] best_prio;
  logic              cand;

  always_comb begin
    start     = (CNT_W'(running) < total) ? CNT_W'(running) : '0;
    pick      = '{found: 1'b0, idx: running};
    best_rank = '0;
    best_prio = PRIO_NONE;
    rank      = '0;
    cand      = 1'b0;
    for (int i = 0; i < MAX_THREADS; i++) begin
      if (CNT_W'(i) > start) begin
        rank = RNK_W'(i) - RNK_W'(start) - RNK_W'(1);
      end else begin
        rank = RNK_W'(i) + RNK_W'(total) - RNK_W'(start) - RNK_W'(1);
      end
      cand = (CNT_W'(i) < total) && ready[i] && (prio[i] != PRIO_NONE);
      if (cand && (!pick.found || (prio[i] < best_prio) ||
                   ((prio[i] == best_prio) && (rank < best_rank)))) begin
        pick.found = 1'b1;
        pick.idx   = IDX_W'(i);
        best_prio  = prio[i];
        best_rank  = rank;
      end
    end
  end

endmodule

// ===== rtl/priority_sleep_thread_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_sleep_thread_scheduler
// Thread table with add, timer tick, sleep and priority schedule operations.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the result side keeps up, and
// returns exactly one result for each: the request is captured in an input
// register, and a single execute stage updates the thread table and loads the
// result register. The schedule operation compares all table entries in
// parallel in that stage, so every operation does all of its work there and
// back-to-back requests run at full rate while the result side takes every
// result. The result reports the running thread after the operation and,
// for an accepted add, the slot given to the new thread.
module priority_sleep_thread_scheduler (
  input  logic        clk,
  input  logic        rst,
  pss_in_if.sink      item,
  pss_out_if.source   result
);
  import pss_pkg::*;

  logic                   s1_valid;
  op_t                    s1_op;
  logic [PRIO_W-1:0]      s1_prio;
  logic [TICK_W-1:0]      s1_ticks;

  prio_vec_t              thread_priority;
  tick_vec_t              sleep_remaining;
  tick_vec_t              sleep_remaining_next;
  logic [MAX_THREADS-1:0] blocked_flag;
  logic [MAX_THREADS-1:0] blocked_flag_next;
  logic [MAX_THREADS-1:0] thread_ready;
  logic [CNT_W-1:0]       thread_total;
  logic [CNT_W-1:0]       thread_total_next;
  logic [IDX_W-1:0]       running_index;
  logic [IDX_W-1:0]       running_index_next;
  logic                   prio_we;
  logic                   status_next;
  logic [IDX_W-1:0]       added_next;

  logic                   res_valid;
  logic                   res_status;
  logic [IDX_W-1:0]       res_running;
  logic [IDX_W-1:0]       res_added;

  logic                   advance;
  logic                   exec;
  pick_t                  pick;

  assign advance    = !res_valid || result.ready;
  assign exec       = s1_valid && advance;
  assign item.ready = !s1_valid || advance;

  always_comb begin
    for (int i = 0; i < MAX_THREADS; i++) begin
      thread_ready[i] = (sleep_remaining[i] == '0) && !blocked_flag[i];
    end
  end

  pss_pick u_pick (
    .prio    (thread_priority),
    .ready   (thread_ready),
    .total   (thread_total),
    .running (running_index),
    .pick    (pick)
  );

  always_comb begin
    sleep_remaining_next = sleep_remaining;
    blocked_flag_next    = blocked_flag;
    thread_total_next    = thread_total;
    running_index_next   = running_index;
    prio_we              = 1'b0;
    status_next          = ST_OK;
    added_next           = '0;
    case (s1_op)
      OP_ADD: begin
        if (thread_total < CNT_W'(MAX_THREADS)) begin
          prio_we                                    = 1'b1;
          sleep_remaining_next[IDX_W'(thread_total)] = s1_ticks;
          blocked_flag_next[IDX_W'(thread_total)]    = 1'b0;
          added_next                                 = IDX_W'(thread_total);
          thread_total_next                          = thread_total + CNT_W'(1);
        end else begin
          status_next = ST_FULL;
        end
      end
      OP_TICK: begin
        for (int i = 0; i < MAX_THREADS; i++) begin
          if ((CNT_W'(i) < thread_total) && (sleep_remaining[i] != '0)) begin
            sleep_remaining_next[i] = sleep_remaining[i] - TICK_W'(1);
            if (sleep_remaining[i] == TICK_W'(1)) begin
              blocked_flag_next[i] = 1'b0;
            end
          end
        end
      end
      OP_SLEEP: begin
        if ((thread_total != '0) && (CNT_W'(running_index) < thread_total)) begin
          sleep_remaining_next[running_index] = s1_ticks;
          blocked_flag_next[running_index]    = 1'b1;
        end
      end
      OP_SCHED: begin
        running_index_next = pick.idx;
      end
      default: begin
        running_index_next = running_index;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_op    <= item.op;
      s1_prio  <= item.priority_req;
      s1_ticks <= item.sleep_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sleep_remaining <= '0;
      blocked_flag    <= '0;
      thread_total    <= '0;
      running_index   <= '0;
    end else if (exec) begin
      sleep_remaining <= sleep_remaining_next;
      blocked_flag    <= blocked_flag_next;
      thread_total    <= thread_total_next;
      running_index   <= running_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && prio_we) begin
      thread_priority[IDX_W'(thread_total)] <= s1_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (exec) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      res_status  <= status_next;
      res_running <= running_index_next;
      res_added   <= added_next;
    end
  end

  assign result.valid          = res_valid;
  assign result.status         = res_status;
  assign result.running_thread = OUT_IDX_W'(res_running);
  assign result.added_index    = OUT_IDX_W'(res_added);

endmodule

// ===== test/tb_priority_sleep_thread_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_sleep_thread_scheduler
// Self-checking bench for the thread scheduler. A behavioral copy of the
// thread table predicts the status, running thread and added slot of every
// request. Directed tests cover the empty table, filling and overflowing the
// table, tick wakeups, tie breaking and the sleep corner cases. Random traffic
// then runs with bursty requests, result-side stalls and one long result hold.
// ----------------------------------------------------------------------------
module tb_priority_sleep_thread_scheduler;
  import pss_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD   = 80;
  localparam int PRINT_CAP   = 40;
  localparam int TAIL_CYCLES = 10;

  typedef struct {
    logic                 status;
    logic [OUT_IDX_W-1:0] running;
    logic [OUT_IDX_W-1:0] added;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pss_in_if  item_ch ();
  pss_out_if result_ch ();

  priority_sleep_thread_scheduler u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  always #5 clk = ~clk;

  // Thread table as the scheduler should see it.
  logic [PRIO_W-1:0] thr_prio    [MAX_THREADS] = '{default: '0};
  logic [TICK_W-1:0] thr_sleep   [MAX_THREADS] = '{default: '0};
  bit                thr_blocked [MAX_THREADS] = '{default: 1'b0};
  int                thr_count  = 0;
  int                cur_thread = 0;

  sched_result_t pending_results[$];
  int            mismatch_count = 0;
  int            cycle_count    = 0;
  int            burst_left     = 0;
  bit            steady         = 1'b0;
  bit            hold_start     = 1'b0;
  int            hold_left      = 0;
  int            rx_left        = 0;
  bit            rx_level       = 1'b0;

  function automatic sched_result_t sched_predict(op_t op, logic [PRIO_W-1:0] prio,
                                                  logic [TICK_W-1:0] ticks);
    sched_result_t res;
    int            scan_base;
    int            best;
    int            pick;
    int            slot;
    res.status = ST_OK;
    res.added  = '0;
    case (op)
      OP_ADD: begin
        if (thr_count < MAX_THREADS) begin
          thr_prio[thr_count]    = prio;
          thr_sleep[thr_count]   = ticks;
          thr_blocked[thr_count] = 1'b0;
          res.added              = OUT_IDX_W'(thr_count);
          thr_count++;
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_TICK: begin
        for (int i = 0; i < thr_count; i++) begin
          if (thr_sleep[i] != 0) begin
            thr_sleep[i]--;
            if (thr_sleep[i] == 0) thr_blocked[i] = 1'b0;
          end
        end
      end
      OP_SLEEP: begin
        if (thr_count != 0 && cur_thread < thr_count) begin
          thr_sleep[cur_thread]   = ticks;
          thr_blocked[cur_thread] = 1'b1;
        end
      end
      default: begin
        if (thr_count != 0) begin
          scan_base = (cur_thread < thr_count) ? cur_thread : 0;
          best      = int'(PRIO_NONE);
          pick      = cur_thread;
          for (int k = 1; k <= thr_count; k++) begin
            slot = (scan_base + k) % thr_count;
            if (thr_sleep[slot] == 0 && !thr_blocked[slot] && int'(thr_prio[slot]) < best) begin
              best = thr_prio[slot];
              pick = slot;
            end
          end
          cur_thread = pick;
        end
      end
    endcase
    res.running = OUT_IDX_W'(cur_thread);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Sends one request; the sender runs in bursts unless steady traffic is on.
  task automatic issue(op_t op, logic [PRIO_W-1:0] prio, logic [TICK_W-1:0] ticks);
    int gap;
    if (!steady && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    item_ch.valid        <= 1'b1;
    item_ch.op           <= op;
    item_ch.priority_req <= prio;
    item_ch.sleep_ticks  <= ticks;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    pending_results.push_back(sched_predict(op, prio, ticks));
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_table();
    issue(OP_SLEEP, 8'($urandom), 32'd5);
    issue(OP_SCHED, 8'($urandom), $urandom);
    issue(OP_TICK, 8'($urandom), $urandom);
  endtask

  // Slot 2 starts asleep, slots 2, 3 and 6 tie on priority, slot 5 has the
  // best priority but sleeps three ticks, and slot 1 can never be chosen.
  task automatic test_fill_table();
    issue(OP_ADD, 8'd10, 32'd0);
    issue(OP_ADD, PRIO_NONE, 32'd0);
    issue(OP_ADD, 8'd3, 32'd2);
    issue(OP_ADD, 8'd3, 32'd0);
    issue(OP_ADD, 8'd200, 32'd0);
    issue(OP_ADD, 8'd0, 32'd3);
    issue(OP_ADD, 8'd3, 32'd0);
    issue(OP_ADD, 8'd254, 32'd1);
    issue(OP_ADD, 8'd0, 32'hFFFF_FFFF);
  endtask

  task automatic test_wakeup_and_ties();
    issue(OP_SCHED, 8'($urandom), $urandom);
    issue(OP_TICK, 8'($urandom), $urandom);
    issue(OP_TICK, 8'($urandom), $urandom);
    issue(OP_SCHED, 8'($urandom), $urandom);
    issue(OP_TICK, 8'($urandom), $urandom);
    issue(OP_SCHED, 8'($urandom), $urandom);
  endtask

  // A zero-length sleep blocks for good, but a later sleep of the same
  // running thread arms its countdown again and lets it wake up.
  task automatic test_sleep_cases();
    issue(OP_SLEEP, 8'($urandom), 32'd0);
    issue(OP_TICK, 8'($urandom), $urandom);
    issue(OP_SLEEP, 8'($urandom), 32'd2);
    issue(OP_TICK, 8'($urandom), $urandom);
    issue(OP_TICK, 8'($urandom), $urandom);
    issue(OP_SCHED, 8'($urandom), $urandom);
  endtask

  task automatic test_random_traffic(int count);
    int               roll;
    int               len_roll;
    op_t              op;
    logic [TICK_W-1:0] ticks;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 5)       op = OP_ADD;
      else if (roll < 45) op = OP_TICK;
      else if (roll < 65) op = OP_SLEEP;
      else                op = OP_SCHED;
      ticks = $urandom;
      if (op == OP_SLEEP) begin
        len_roll = $urandom_range(399);
        if (len_roll == 0)      ticks = '0;
        else if (len_roll == 1) ticks = $urandom;
        else if (len_roll < 40) ticks = $urandom_range(9, 40);
        else                    ticks = $urandom_range(1, 8);
      end
      issue(op, 8'($urandom), ticks);
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_start = 1'b1;
    while (hold_left == 0) @(posedge clk);
    steady = 1'b1;
    test_random_traffic(60);
    steady = 1'b0;
    wait_drained();
  endtask

  always @(posedge clk) begin : sink_pacing
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left  = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else if (steady) begin
      result_ch.ready <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_level = !rx_level;
        rx_left  = rx_level ? $urandom_range(1, 12) : $urandom_range(1, 4);
      end
      rx_left--;
      result_ch.ready <= rx_level;
    end
  end

  always @(posedge clk) begin : result_check
    sched_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", result_ch.running_thread, 0);
      end else begin
        want = pending_results.pop_front();
        if (result_ch.status !== want.status)
          report_mismatch("status", result_ch.status, want.status);
        if (result_ch.running_thread !== want.running)
          report_mismatch("running_thread", result_ch.running_thread, want.running);
        if (result_ch.added_index !== want.added)
          report_mismatch("added_index", result_ch.added_index, want.added);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("priority_sleep_thread_scheduler regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    item_ch.valid        = 1'b0;
    item_ch.op           = OP_ADD;
    item_ch.priority_req = '0;
    item_ch.sleep_ticks  = '0;
    result_ch.ready      = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_fill_table();
    test_wakeup_and_ties();
    test_sleep_cases();
    test_random_traffic(600);
    test_backpressure();
    steady = 1'b1;
    test_random_traffic(600);
    steady = 1'b0;
    test_random_traffic(590);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("priority_sleep_thread_scheduler regression: pass");
    end else begin
      $display("priority_sleep_thread_scheduler regression: fail");
    end
    $finish;
  end

endmodule
